>>> rtl/core/bifc_pkg.sv
// Shared types, sizes and constants of the block index FIFO cache.
package bifc_pkg;

   localparam int ENTRIES  = 16;
   localparam int TAG_W    = 52;
   localparam int HANDLE_W = 24;
   localparam int LIMIT_W  = 5;
   localparam int AGE_W    = 5;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int CMP_W    = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(17);
   localparam logic [AGE_W-1:0]   AGE_MAX     = '1;
   localparam logic [AGE_W-1:0]   AGE_FILL    = AGE_W'(1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [TAG_W-1:0]    block_index;
      logic                backing_present;
      logic [HANDLE_W-1:0] block_handle;
   } req_item_type;

   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] handle_out;
      logic                filled;
      logic                evicted;
      logic [TAG_W-1:0]    victim_index;
   } rsp_item_type;

   typedef enum logic [0:0] {
      ENG_SEARCH,
      ENG_COMMIT
   } eng_state_type;

endpackage

>>> rtl/core/block_index_fifo_cache_core.sv
// Top level of the block index FIFO cache: queues, engine and capacity register.
//
//   port group  | direction | handshake                 | payload
//   ------------+-----------+---------------------------+------------------------------------
//   request     | in        | push / full               | req_block_index, req_backing_present,
//               |           |                           | req_block_handle
//   response    | out       | empty / pop               | rsp_hit, rsp_handle_out, rsp_filled,
//               |           |                           | rsp_evicted, rsp_victim_index
//   csr         | in        | csr_write_enable          | csr_write_data (capacity limit)
//
// The engine handles a request in a search state, which checks all tags and ages of the
// shared entry store, then a commit state, which writes the fill or eviction and emits
// the response; it takes no new request until the commit is done.
// Reset clears both queues, all entry valid bits and the occupancy count; capacity is 17.
// The request queue keeps taking requests until it is full while the response queue is
// held by a stalled consumer; the engine waits with no request or a full response queue.
module block_index_fifo_cache_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          push,
   output logic                          full,
   input  logic [bifc_pkg::TAG_W-1:0]    req_block_index,
   input  logic                          req_backing_present,
   input  logic [bifc_pkg::HANDLE_W-1:0] req_block_handle,
   // response channel
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_hit,
   output logic [bifc_pkg::HANDLE_W-1:0] rsp_handle_out,
   output logic                          rsp_filled,
   output logic                          rsp_evicted,
   output logic [bifc_pkg::TAG_W-1:0]    rsp_victim_index,
   // configuration
   input  logic                          csr_write_enable,
   input  logic [bifc_pkg::LIMIT_W-1:0]  csr_write_data
);

   logic [bifc_pkg::LIMIT_W-1:0] capacity_limit_ff, capacity_limit_in;

   bifc_pkg::req_item_type req_in_item, req_head;
   bifc_pkg::rsp_item_type rsp_push_item, rsp_head;
   logic req_empty_int, req_pop_int;
   logic rsp_full_int, rsp_push_int;

   // capacity register: the user must write it only while the block is idle; the block does not enforce this
   assign capacity_limit_in = csr_write_enable ? csr_write_data : capacity_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_limit_ff <= bifc_pkg::LIMIT_RESET;
      end else begin
         capacity_limit_ff <= capacity_limit_in;
      end
   end

   // pack the request fields
   always_comb begin
      req_in_item.block_index     = req_block_index;
      req_in_item.backing_present = req_backing_present;
      req_in_item.block_handle    = req_block_handle;
   end

   bifc_req_queue u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (req_in_item),
      .full      (full),
      .empty     (req_empty_int),
      .pop       (req_pop_int),
      .head_item (req_head)
   );

   bifc_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .capacity_limit (capacity_limit_ff),
      .req_item       (req_head),
      .req_empty      (req_empty_int),
      .req_pop        (req_pop_int),
      .rsp_full       (rsp_full_int),
      .rsp_push       (rsp_push_int),
      .rsp_item       (rsp_push_item)
   );

   bifc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push_int),
      .push_item (rsp_push_item),
      .full      (rsp_full_int),
      .empty     (empty),
      .pop       (pop),
      .head_item (rsp_head)
   );

   // unpack the oldest response
   assign rsp_hit          = rsp_head.hit;
   assign rsp_handle_out   = rsp_head.handle_out;
   assign rsp_filled       = rsp_head.filled;
   assign rsp_evicted      = rsp_head.evicted;
   assign rsp_victim_index = rsp_head.victim_index;

   // the engine never drops a response into a full queue
   assert property (@(posedge clock) disable iff (reset) rsp_push_int |-> !rsp_full_int)
      else $error("response pushed into a full queue");

   // every request taken by the engine yields a response on the next cycle
   assert property (@(posedge clock) disable iff (reset) req_pop_int |=> rsp_push_int)
      else $error("request taken without a response");

   // an eviction only comes with a fill, and no victim is reported without one
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((!rsp_evicted || rsp_filled) && (rsp_evicted || rsp_victim_index == '0)))
      else $error("inconsistent eviction fields");

   // a hit never fills
   assert property (@(posedge clock) disable iff (reset) !empty |-> !(rsp_hit && rsp_filled))
      else $error("hit and fill reported together");

endmodule

>>> rtl/core/bifc_req_queue.sv
// Short request queue between the port and the lookup engine.
module bifc_req_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bifc_pkg::req_item_type push_item,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output bifc_pkg::req_item_type head_item
);

   bifc_pkg::req_item_type slot_ff [bifc_pkg::QUEUE_DEPTH];
   logic [bifc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bifc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bifc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == bifc_pkg::QCNT_W'(bifc_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == bifc_pkg::QPTR_W'(bifc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bifc_pkg::QPTR_W'(bifc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + bifc_pkg::QCNT_W'(do_push) - bifc_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/bifc_rsp_queue.sv
// Short result queue between the lookup engine and the port.
module bifc_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bifc_pkg::rsp_item_type push_item,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output bifc_pkg::rsp_item_type head_item
);

   bifc_pkg::rsp_item_type slot_ff [bifc_pkg::QUEUE_DEPTH];
   logic [bifc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bifc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bifc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == bifc_pkg::QCNT_W'(bifc_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == bifc_pkg::QPTR_W'(bifc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bifc_pkg::QPTR_W'(bifc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + bifc_pkg::QCNT_W'(do_push) - bifc_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/bifc_engine.sv
// Lookup engine: entry store, search of tags and ages, fill and eviction.
module bifc_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bifc_pkg::LIMIT_W-1:0] capacity_limit,
   input  bifc_pkg::req_item_type        req_item,
   input  logic                         req_empty,
   output logic                         req_pop,
   input  logic                         rsp_full,
   output logic                         rsp_push,
   output bifc_pkg::rsp_item_type        rsp_item
);

   // entry store
   logic [bifc_pkg::ENTRIES-1:0]  valid_ff, valid_in;
   logic [bifc_pkg::TAG_W-1:0]    tag_ff    [bifc_pkg::ENTRIES];
   logic [bifc_pkg::HANDLE_W-1:0] handle_ff [bifc_pkg::ENTRIES];
   logic [bifc_pkg::AGE_W-1:0]    age_ff    [bifc_pkg::ENTRIES];
   logic [bifc_pkg::CNT_W-1:0]    count_ff, count_in;

   bifc_pkg::eng_state_type state_ff, state_in;

   // search results held for the commit cycle
   bifc_pkg::req_item_type        item_ff;
   logic                          hit_ff;
   logic [bifc_pkg::HANDLE_W-1:0] hit_handle_ff;
   logic                          evict_ff;
   logic [bifc_pkg::IDX_W-1:0]    slot_ff;
   logic [bifc_pkg::TAG_W-1:0]    victim_ff;

   logic [bifc_pkg::ENTRIES-1:0]  match_oh, oldest_oh;
   logic                          hit;
   logic [bifc_pkg::HANDLE_W-1:0] hit_handle;
   logic [bifc_pkg::IDX_W-1:0]    oldest_idx, free_idx, slot;
   logic [bifc_pkg::TAG_W-1:0]    oldest_tag;
   logic [bifc_pkg::CMP_W-1:0]    cap_eff, occ_next;
   logic                          evict, capture, fill;

   // tag match and handle select
   always_comb begin
      hit_handle = '0;
      for (int i = 0; i < bifc_pkg::ENTRIES; i++) begin
         match_oh[i] = valid_ff[i] && (tag_ff[i] == req_item.block_index);
         hit_handle  = hit_handle | ({bifc_pkg::HANDLE_W{match_oh[i]}} & handle_ff[i]);
      end
      hit = |match_oh;
   end

   // oldest valid entry: largest age, lowest slot on a tie
   always_comb begin
      logic older;
      for (int i = 0; i < bifc_pkg::ENTRIES; i++) begin
         older = valid_ff[i];
         for (int j = 0; j < bifc_pkg::ENTRIES; j++) begin
            if (j != i && valid_ff[j]) begin
               if (age_ff[j] > age_ff[i] || (age_ff[j] == age_ff[i] && j < i)) begin
                  older = 1'b0;
               end
            end
         end
         oldest_oh[i] = older;
      end
   end

   always_comb begin
      oldest_idx = '0;
      oldest_tag = '0;
      for (int i = 0; i < bifc_pkg::ENTRIES; i++) begin
         oldest_idx = oldest_idx | ({bifc_pkg::IDX_W{oldest_oh[i]}} & bifc_pkg::IDX_W'(i));
         oldest_tag = oldest_tag | ({bifc_pkg::TAG_W{oldest_oh[i]}} & tag_ff[i]);
      end
   end

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = bifc_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = bifc_pkg::IDX_W'(i);
         end
      end
   end

   // evict when an entry is valid and occupancy after the fill reaches the clamped capacity
   always_comb begin
      cap_eff  = (bifc_pkg::CMP_W'(capacity_limit) > bifc_pkg::CMP_W'(bifc_pkg::ENTRIES + 1)) ?
                 bifc_pkg::CMP_W'(bifc_pkg::ENTRIES + 1) : bifc_pkg::CMP_W'(capacity_limit);
      occ_next = bifc_pkg::CMP_W'(count_ff) + bifc_pkg::CMP_W'(1);
      evict    = (|valid_ff) && (occ_next >= cap_eff);
      slot     = evict ? oldest_idx : free_idx;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bifc_pkg::ENG_SEARCH: begin
            if (!req_empty && !rsp_full) begin
               state_in = bifc_pkg::ENG_COMMIT;
            end
         end
         bifc_pkg::ENG_COMMIT: state_in = bifc_pkg::ENG_SEARCH;
         default:              state_in = bifc_pkg::ENG_SEARCH;
      endcase
   end

   // state outputs
   always_comb begin
      req_pop  = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         bifc_pkg::ENG_SEARCH: req_pop  = !req_empty && !rsp_full;
         bifc_pkg::ENG_COMMIT: rsp_push = 1'b1;
         default: begin
            req_pop  = 1'b0;
            rsp_push = 1'b0;
         end
      endcase
   end

   assign capture = req_pop;
   assign fill    = rsp_push && !hit_ff && item_ff.backing_present;

   always_ff @(posedge clock) begin
      if (capture) begin
         item_ff       <= req_item;
         hit_ff        <= hit;
         hit_handle_ff <= hit_handle;
         evict_ff      <= evict;
         slot_ff       <= slot;
         victim_ff     <= evict ? oldest_tag : '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (fill) begin
         valid_in[slot_ff] = 1'b1;
         if (!evict_ff) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bifc_pkg::ENG_SEARCH;
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // on a fill, age every other resident entry up to AGE_MAX; the filled slot starts over at age one
   always_ff @(posedge clock) begin
      if (fill) begin
         for (int i = 0; i < bifc_pkg::ENTRIES; i++) begin
            if (bifc_pkg::IDX_W'(i) == slot_ff) begin
               age_ff[i] <= bifc_pkg::AGE_FILL;
            end else if (valid_ff[i] && age_ff[i] != bifc_pkg::AGE_MAX) begin
               age_ff[i] <= age_ff[i] + 1'b1;
            end
         end
         tag_ff[slot_ff]    <= item_ff.block_index;
         handle_ff[slot_ff] <= item_ff.block_handle;
      end
   end

   always_comb begin
      rsp_item = '0;
      if (hit_ff) begin
         rsp_item.hit        = 1'b1;
         rsp_item.handle_out = hit_handle_ff;
      end else if (item_ff.backing_present) begin
         rsp_item.handle_out   = item_ff.block_handle;
         rsp_item.filled       = 1'b1;
         rsp_item.evicted      = evict_ff;
         rsp_item.victim_index = victim_ff;
      end
   end

endmodule

>>> sim/bifc_lookup_checker.sv
// Lookup checker for the block index FIFO cache: predicts every response and compares it.
module bifc_lookup_checker
   import bifc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                full,
   input  logic [TAG_W-1:0]    req_block_index,
   input  logic                req_backing_present,
   input  logic [HANDLE_W-1:0] req_block_handle,
   input  logic                empty,
   input  logic                pop,
   input  logic                rsp_hit,
   input  logic [HANDLE_W-1:0] rsp_handle_out,
   input  logic                rsp_filled,
   input  logic                rsp_evicted,
   input  logic [TAG_W-1:0]    rsp_victim_index,
   input  logic                csr_write_enable,
   input  logic [LIMIT_W-1:0]  csr_write_data,
   output int                  mismatch_count,
   output int                  lookups_in_flight
);

   logic                slot_valid  [ENTRIES];
   logic [TAG_W-1:0]    slot_tag    [ENTRIES];
   logic [HANDLE_W-1:0] slot_handle [ENTRIES];
   logic [AGE_W-1:0]    slot_age    [ENTRIES];
   logic [LIMIT_W-1:0]  capacity;

   rsp_item_type pending_lookups[$];
   rsp_item_type seen_rsp;
   rsp_item_type want_rsp;
   req_item_type seen_req;

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
      end
      capacity          = LIMIT_RESET;
      mismatch_count    = 0;
      lookups_in_flight = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("[%0t] lookup mismatch: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
   endtask

   // Search, then on a backed miss age every resident entry and fill (evicting the oldest at capacity).
   function automatic rsp_item_type lookup_and_fill(input req_item_type rq);
      rsp_item_type       r;
      int                 count;
      int                 oldest;
      int                 free_slot;
      int                 slot;
      int                 cap;
      logic [AGE_W-1:0]   oldest_age;
      logic               evict;
      r          = '0;
      count      = 0;
      oldest     = -1;
      free_slot  = -1;
      oldest_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_tag[i] == rq.block_index) begin
            r.hit        = 1'b1;
            r.handle_out = slot_handle[i];
            return r;
         end
      end
      if (!rq.backing_present) begin
         return r;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i]) begin
            count++;
            if (oldest < 0 || slot_age[i] > oldest_age) begin
               oldest     = i;
               oldest_age = slot_age[i];
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      cap = int'(capacity);
      if (cap > ENTRIES + 1) begin
         cap = ENTRIES + 1;
      end
      evict = (oldest >= 0) && (count + 1 >= cap);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_age[i] != AGE_MAX) begin
            slot_age[i] = slot_age[i] + 1'b1;
         end
      end
      if (evict) begin
         r.evicted          = 1'b1;
         r.victim_index     = slot_tag[oldest];
         slot_valid[oldest] = 1'b0;
         slot = oldest;
      end else begin
         slot = free_slot;
      end
      if (slot < 0) begin
         slot = 0;
      end
      slot_valid[slot]  = 1'b1;
      slot_tag[slot]    = rq.block_index;
      slot_handle[slot] = rq.block_handle;
      slot_age[slot]    = AGE_FILL;
      r.handle_out      = rq.block_handle;
      r.filled          = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            capacity = csr_write_data;
         end
         if (pop && !empty) begin
            seen_rsp = '{rsp_hit, rsp_handle_out, rsp_filled, rsp_evicted, rsp_victim_index};
            if (pending_lookups.size() == 0) begin
               report_mismatch("response popped with no request outstanding");
            end else begin
               want_rsp = pending_lookups.pop_front();
               check_field("hit", 64'(seen_rsp.hit), 64'(want_rsp.hit));
               check_field("handle_out", 64'(seen_rsp.handle_out), 64'(want_rsp.handle_out));
               check_field("filled", 64'(seen_rsp.filled), 64'(want_rsp.filled));
               check_field("evicted", 64'(seen_rsp.evicted), 64'(want_rsp.evicted));
               check_field("victim_index", 64'(seen_rsp.victim_index),
                           64'(want_rsp.victim_index));
            end
         end
         if (push && !full) begin
            seen_req = '{req_block_index, req_backing_present, req_block_handle};
            pending_lookups.push_back(lookup_and_fill(seen_req));
         end
         lookups_in_flight = pending_lookups.size();
      end
   end

endmodule

>>> sim/block_index_fifo_cache_core_tb.sv
// Testbench top for the block index FIFO cache: clock, reset, request stimulus and verdict.
module block_index_fifo_cache_core_tb;
   import bifc_pkg::*;

   // Generous bound: ~1125 requests, each at worst a long send gap plus a long pop stall.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 138;
   localparam int POOL_MAX    = 20;

   logic                clock;
   logic                reset;
   logic                push;
   logic                full;
   logic [TAG_W-1:0]    req_block_index;
   logic                req_backing_present;
   logic [HANDLE_W-1:0] req_block_handle;
   logic                empty;
   logic                pop;
   logic                rsp_hit;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic                rsp_filled;
   logic                rsp_evicted;
   logic [TAG_W-1:0]    rsp_victim_index;
   logic                csr_write_enable;
   logic [LIMIT_W-1:0]  csr_write_data;

   int mismatch_count;
   int lookups_in_flight;
   int cycle_count = 0;

   // Sender burst: number of upcoming requests sent back to back.
   int sender_burst = 0;
   // Receiver pacing: cycles left in a pop stall, and cycles left of steady popping.
   int stall_left  = 0;
   int steady_left = 0;

   logic [TAG_W-1:0] tag_pool [POOL_MAX];
   int               pool_size;

   block_index_fifo_cache_core dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_block_index     (req_block_index),
      .req_backing_present (req_backing_present),
      .req_block_handle    (req_block_handle),
      .empty               (empty),
      .pop                 (pop),
      .rsp_hit             (rsp_hit),
      .rsp_handle_out      (rsp_handle_out),
      .rsp_filled          (rsp_filled),
      .rsp_evicted         (rsp_evicted),
      .rsp_victim_index    (rsp_victim_index),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   bifc_lookup_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_block_index     (req_block_index),
      .req_backing_present (req_backing_present),
      .req_block_handle    (req_block_handle),
      .empty               (empty),
      .pop                 (pop),
      .rsp_hit             (rsp_hit),
      .rsp_handle_out      (rsp_handle_out),
      .rsp_filled          (rsp_filled),
      .rsp_evicted         (rsp_evicted),
      .rsp_victim_index    (rsp_victim_index),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .lookups_in_flight   (lookups_in_flight)
   );

   always #5 clock = ~clock;

   // Abort the run if it never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Pace the response side: mostly popping, with short and occasional long stalls,
   // and stretches of steady popping so the response queue also sees no back-pressure.
   always @(posedge clock) begin : pop_pacing
      int r;
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left--;
      end else begin
         pop <= 1'b1;
         if (steady_left > 0) begin
            steady_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               steady_left = $urandom_range(30, 100);
            end else if (r < 30) begin
               stall_left = $urandom_range(1, 3);
            end else if (r < 36) begin
               stall_left = $urandom_range(4, 12);
            end else if (r < 38) begin
               stall_left = $urandom_range(20, 60);
            end
         end
      end
   end

   function automatic logic [TAG_W-1:0] rand_tag();
      return TAG_W'({$urandom(), $urandom()});
   endfunction

   // Pick the idle gap ahead of the next request: mostly none or short, a few long,
   // and now and then a burst with no gaps at all.
   function automatic int pick_gap();
      int r;
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         sender_burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 82) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one request and hold it until the block takes it. Push stays high on
   // exit so a back-to-back request never drops and re-raises it in one time step.
   task automatic send_request(input logic [TAG_W-1:0] tag, input logic present,
                               input logic [HANDLE_W-1:0] handle);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push                <= 1'b1;
      req_block_index     <= tag;
      req_backing_present <= present;
      req_block_handle    <= handle;
      do @(posedge clock); while (full);
   endtask

   // Stop sending and wait until every outstanding request has its response,
   // then let the engine settle.
   task automatic drain_requests();
      push <= 1'b0;
      do @(posedge clock); while (lookups_in_flight != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write the capacity limit; only called with the block idle.
   task automatic write_capacity(input logic [LIMIT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Build a tag pool for a phase: zero and all-ones always in it, sized near the
   // capacity so hits, fills and evictions all happen.
   task automatic build_pool(input int cap);
      pool_size = cap + 3;
      if (pool_size < 3) pool_size = 3;
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < POOL_MAX; i++) begin
         tag_pool[i] = ($urandom_range(0, 3) == 0) ? TAG_W'(i) : rand_tag();
      end
   endtask

   // One random request: mostly pool tags, some fresh tags, some near misses.
   task automatic send_random_request();
      int                  r;
      logic [TAG_W-1:0]    tag;
      logic [HANDLE_W-1:0] handle;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         tag = tag_pool[$urandom_range(0, pool_size - 1)];
      end else if (r < 85) begin
         tag = rand_tag();
      end else begin
         tag = tag_pool[$urandom_range(0, pool_size - 1)];
         tag[$urandom_range(0, TAG_W - 1)] ^= 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         handle = '0;
      end else if (r < 6) begin
         handle = '1;
      end else begin
         handle = HANDLE_W'($urandom());
      end
      send_request(tag, ($urandom_range(0, 99) < 80), handle);
   endtask

   initial begin
      int unsigned phase_caps [PHASES];
      clock               = 1'b0;
      reset               = 1'b1;
      push                = 1'b0;
      req_block_index     = '0;
      req_backing_present = 1'b0;
      req_block_handle    = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      phase_caps = '{2, 0, 31, 1, 9, 16, 17, 0};
      phase_caps[PHASES-1] = $urandom_range(0, 31);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Capacity of one: a fill into the empty cache evicts nothing, the next fill
      // evicts block index zero.
      write_capacity(LIMIT_W'(1));
      send_request('0, 1'b1, '0);
      send_request('1, 1'b1, '1);
      // Hit with backing absent, then miss with backing absent (no change).
      send_request('1, 1'b0, HANDLE_W'($urandom()));
      send_request('0, 1'b0, HANDLE_W'($urandom()));
      drain_requests();

      // Capacity at reset value: fill the whole store, then one more fill evicts the
      // oldest entry (the all-ones tag) and reuses its slot.
      write_capacity(LIMIT_RESET);
      send_request('0, 1'b1, HANDLE_W'($urandom()));
      for (int i = 0; i < ENTRIES - 2; i++) begin
         send_request(rand_tag(), 1'b1, HANDLE_W'($urandom()));
      end
      send_request(rand_tag(), 1'b1, '1);
      send_request('0, 1'b0, '0);
      drain_requests();

      // Random phases, each at its own capacity; drain before every register write.
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(LIMIT_W'(phase_caps[p]));
         build_pool(int'(phase_caps[p]));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_request();
         end
         drain_requests();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && lookups_in_flight == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
